// ===== rtl/bmid_pkg.sv =====
// Package for the bus-mapped integer divider.
// Widths, register and read codes, divider sequencer states and status types.
// No dependencies.
`default_nettype none

package bmid_pkg;

    localparam int WORD_W  = 16;
    localparam int NUM_W   = 2 * WORD_W;
    localparam int ITERS   = NUM_W;
    localparam int CNT_W   = $clog2(ITERS);
    localparam int FLAG_W  = 2;

    localparam logic [WORD_W-1:0] UNMAPPED_WORD = 16'hFFFF;
    localparam logic [WORD_W-1:0] Q_MAX         = 16'h7FFF;
    localparam logic [WORD_W-1:0] Q_MIN         = 16'h8000;
    localparam logic [NUM_W-1:0]  MAG_POS_MAX   = 32'd32767;
    localparam logic [NUM_W-1:0]  MAG_NEG_MAX   = 32'd32768;

    // flag bit positions
    localparam int FLAG_ZERO_DIV = 0;
    localparam int FLAG_OVERFLOW = 1;

    // access kind
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // write register select, offset bits 1:0
    localparam logic [1:0] SEL_DIV_HI  = 2'd0;
    localparam logic [1:0] SEL_DIV_LO  = 2'd1;
    localparam logic [1:0] SEL_DIVISOR = 2'd2;
    localparam logic [1:0] SEL_NONE    = 2'd3;

    // read word select, offset bits 2:0
    localparam logic [2:0] RD_DIV_HI  = 3'd0;
    localparam logic [2:0] RD_DIV_LO  = 3'd1;
    localparam logic [2:0] RD_DIVISOR = 3'd2;
    localparam logic [2:0] RD_RES_HI  = 3'd4;
    localparam logic [2:0] RD_RES_LO  = 3'd5;
    localparam logic [2:0] RD_STATUS  = 3'd6;

    // offset bit positions
    localparam int OFS_START_BIT = 3;
    localparam int OFS_MODE_BIT  = 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_ITER = 4'b0100,
        ST_FIN  = 4'b1000
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bmid_req_if.sv =====
// Request channel of the bus-mapped integer divider: one bus access per item.
// Depends on bmid_pkg for the word width.
`default_nettype none

interface bmid_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [3:0]                  offset;
    logic [bmid_pkg::WORD_W-1:0] write_data;
    logic [bmid_pkg::WORD_W-1:0] keep_mask;

    modport source (output valid, kind, offset, write_data, keep_mask, input ready);
    modport sink   (input valid, kind, offset, write_data, keep_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmid_rsp_if.sv =====
// Response channel of the bus-mapped integer divider: one read word per item.
// Depends on bmid_pkg for the word width.
`default_nettype none

interface bmid_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bmid_pkg::WORD_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmid_div.sv =====
// Radix-2 restoring divider with sign handling, saturation and result registers.
// One shared subtract/compare unit stepped by a small sequencer. Depends on bmid_pkg.
`default_nettype none

module bmid_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          mode_unsigned,
    input  wire logic [bmid_pkg::NUM_W-1:0]    dividend,
    input  wire logic [bmid_pkg::WORD_W-1:0]   divisor,
    output logic      [bmid_pkg::WORD_W-1:0]   result_high,
    output logic      [bmid_pkg::WORD_W-1:0]   result_low,
    output logic      [bmid_pkg::FLAG_W-1:0]   flags,
    output bmid_pkg::div_stat_t                stat
);

    bmid_pkg::div_state_t              state_reg, state_next;
    logic [bmid_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              mode_reg, mode_next;
    logic                              sn_reg, sn_next;
    logic                              sd_reg, sd_next;
    logic                              dz_reg, dz_next;
    logic [bmid_pkg::WORD_W-1:0]       dmag_reg, dmag_next;
    logic [bmid_pkg::WORD_W-1:0]       rem_reg, rem_next;
    logic [bmid_pkg::NUM_W-1:0]        quo_reg, quo_next;
    logic [bmid_pkg::WORD_W-1:0]       res_hi_reg, res_hi_next;
    logic [bmid_pkg::WORD_W-1:0]       res_lo_reg, res_lo_next;
    logic [bmid_pkg::FLAG_W-1:0]       flags_reg, flags_next;

    logic [bmid_pkg::WORD_W:0]         shifted;
    logic [bmid_pkg::WORD_W:0]         trial;
    logic                              qneg;
    logic                              ovf;
    logic [bmid_pkg::WORD_W-1:0]       q16;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        sn_next     = sn_reg;
        sd_next     = sd_reg;
        dz_next     = dz_reg;
        dmag_next   = dmag_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        res_hi_next = res_hi_reg;
        res_lo_next = res_lo_reg;
        flags_next  = flags_reg;

        shifted = {rem_reg, quo_reg[bmid_pkg::NUM_W-1]};
        trial   = shifted - {1'b0, dmag_reg};
        qneg    = sn_reg ^ sd_reg;
        ovf     = 1'b0;
        q16     = '0;

        unique case (state_reg)
            bmid_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode_unsigned;
                    state_next = bmid_pkg::ST_LOAD;
                end
            end
            bmid_pkg::ST_LOAD:
            begin
                dz_next   = (divisor == '0);
                sn_next   = !mode_reg && dividend[bmid_pkg::NUM_W-1];
                sd_next   = !mode_reg && divisor[bmid_pkg::WORD_W-1];
                dmag_next = sd_next ? (-divisor) : divisor;
                rem_next  = '0;
                cnt_next  = bmid_pkg::CNT_W'(bmid_pkg::ITERS - 1);
                if (dz_next)
                begin
                    quo_next   = dividend;
                    state_next = bmid_pkg::ST_FIN;
                end
                else
                begin
                    quo_next   = sn_next ? (-dividend) : dividend;
                    state_next = bmid_pkg::ST_ITER;
                end
            end
            bmid_pkg::ST_ITER:
            begin
                if (!trial[bmid_pkg::WORD_W])
                begin
                    rem_next = trial[bmid_pkg::WORD_W-1:0];
                    quo_next = {quo_reg[bmid_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[bmid_pkg::WORD_W-1:0];
                    quo_next = {quo_reg[bmid_pkg::NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bmid_pkg::ST_FIN;
            end
            bmid_pkg::ST_FIN:
            begin
                if (mode_reg)
                begin
                    res_hi_next = quo_reg[bmid_pkg::NUM_W-1:bmid_pkg::WORD_W];
                    res_lo_next = quo_reg[bmid_pkg::WORD_W-1:0];
                end
                else if (dz_reg)
                begin
                    // quotient is the dividend itself, remainder its low word
                    ovf = !((quo_reg[bmid_pkg::NUM_W-1:bmid_pkg::WORD_W-1] == '0) ||
                            (quo_reg[bmid_pkg::NUM_W-1:bmid_pkg::WORD_W-1] == '1));
                    res_hi_next = ovf ? (quo_reg[bmid_pkg::NUM_W-1] ? bmid_pkg::Q_MIN
                                                                    : bmid_pkg::Q_MAX)
                                      : quo_reg[bmid_pkg::WORD_W-1:0];
                    res_lo_next = quo_reg[bmid_pkg::WORD_W-1:0];
                end
                else
                begin
                    ovf = qneg ? (quo_reg > bmid_pkg::MAG_NEG_MAX)
                               : (quo_reg > bmid_pkg::MAG_POS_MAX);
                    q16 = qneg ? (-quo_reg[bmid_pkg::WORD_W-1:0])
                               : quo_reg[bmid_pkg::WORD_W-1:0];
                    res_hi_next = ovf ? (qneg ? bmid_pkg::Q_MIN : bmid_pkg::Q_MAX) : q16;
                    res_lo_next = sn_reg ? (-rem_reg) : rem_reg;
                end
                flags_next[bmid_pkg::FLAG_ZERO_DIV] = dz_reg;
                flags_next[bmid_pkg::FLAG_OVERFLOW] = ovf;
                state_next = bmid_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bmid_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bmid_pkg::ST_IDLE;
            res_hi_reg <= '0;
            res_lo_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            res_hi_reg <= res_hi_next;
            res_lo_reg <= res_lo_next;
            flags_reg  <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
        sn_reg   <= sn_next;
        sd_reg   <= sd_next;
        dz_reg   <= dz_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign result_high = res_hi_reg;
    assign result_low  = res_lo_reg;
    assign flags       = flags_reg;
    assign stat.busy   = (state_reg != bmid_pkg::ST_IDLE);
    assign stat.done   = (state_reg == bmid_pkg::ST_FIN);

endmodule

`default_nettype wire

// ===== rtl/bus_mapped_integer_divider.sv =====
// Top level of the bus-mapped integer divider: bus registers, read mux, output register.
// Depends on bmid_pkg, bmid_req_if, bmid_rsp_if and bmid_div.
//
// channel  dir  payload                                  handshake
// req      in   kind, offset, write_data, keep_mask      valid/ready
// rsp      out  read_data (reads only)                   valid/ready
//
// A plain write updates the bus registers; a read's word is held in an output register.
// A write with offset bit 3 starts a division: 1 load, 32 shift/subtract steps of the one
// divider unit, 1 fix-up; a zero divisor goes from load straight to fix-up; req.ready is low
// meanwhile. req.ready is also low while a read word waits and rsp.ready is low.
// Reset clears the bus registers, the divider results and the flags to zero.
`default_nettype none

module bus_mapped_integer_divider (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmid_req_if.sink    req,
    bmid_rsp_if.source  rsp
);

    logic [bmid_pkg::WORD_W-1:0] div_hi_reg, div_hi_next;
    logic [bmid_pkg::WORD_W-1:0] div_lo_reg, div_lo_next;
    logic [bmid_pkg::WORD_W-1:0] divisor_reg, divisor_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [bmid_pkg::WORD_W-1:0] rsp_data_reg, rsp_data_next;

    logic [bmid_pkg::WORD_W-1:0] res_hi;
    logic [bmid_pkg::WORD_W-1:0] res_lo;
    logic [bmid_pkg::FLAG_W-1:0] flags;
    bmid_pkg::div_stat_t         div_stat;

    logic                        accept;
    logic                        is_write;
    logic                        div_start;
    logic [bmid_pkg::WORD_W-1:0] merged;
    logic [bmid_pkg::WORD_W-1:0] rd_word;

    assign req.ready = !div_stat.busy && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_write  = (req.kind == bmid_pkg::KIND_WRITE);
    assign div_start = accept && is_write && req.offset[bmid_pkg::OFS_START_BIT];

    always_comb
    begin
        div_hi_next  = div_hi_reg;
        div_lo_next  = div_lo_reg;
        divisor_next = divisor_reg;
        merged       = '0;
        if (accept && is_write)
        begin
            unique case (req.offset[1:0])
                bmid_pkg::SEL_DIV_HI:
                begin
                    merged      = (div_hi_reg & req.keep_mask) | (req.write_data & ~req.keep_mask);
                    div_hi_next = merged;
                end
                bmid_pkg::SEL_DIV_LO:
                begin
                    merged      = (div_lo_reg & req.keep_mask) | (req.write_data & ~req.keep_mask);
                    div_lo_next = merged;
                end
                bmid_pkg::SEL_DIVISOR:
                begin
                    merged       = (divisor_reg & req.keep_mask) | (req.write_data & ~req.keep_mask);
                    divisor_next = merged;
                end
                bmid_pkg::SEL_NONE:
                begin
                    merged = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (req.offset[2:0])
            bmid_pkg::RD_DIV_HI:  rd_word = div_hi_reg;
            bmid_pkg::RD_DIV_LO:  rd_word = div_lo_reg;
            bmid_pkg::RD_DIVISOR: rd_word = divisor_reg;
            bmid_pkg::RD_RES_HI:  rd_word = res_hi;
            bmid_pkg::RD_RES_LO:  rd_word = res_lo;
            bmid_pkg::RD_STATUS:  rd_word = {flags, {(bmid_pkg::WORD_W - bmid_pkg::FLAG_W){1'b0}}};
            default:              rd_word = bmid_pkg::UNMAPPED_WORD;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        if (accept && !is_write)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = rd_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_hi_reg    <= '0;
            div_lo_reg    <= '0;
            divisor_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            div_hi_reg    <= div_hi_next;
            div_lo_reg    <= div_lo_next;
            divisor_reg   <= divisor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    bmid_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .mode_unsigned (req.offset[bmid_pkg::OFS_MODE_BIT]),
        .dividend      ({div_hi_reg, div_lo_reg}),
        .divisor       (divisor_reg),
        .result_high   (res_hi),
        .result_low    (res_lo),
        .flags         (flags),
        .stat          (div_stat)
    );

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy)
        else $error("divider not busy after start");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !req.ready)
        else $error("request taken while dividing");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> !div_stat.busy)
        else $error("divider still busy after fix-up");

    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(accept && !is_write))
        else $error("read word without read item");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bus_mapped_integer_divider: bus reads and writes, signed and
// unsigned divisions, with random idling on the request and response channels.
// Depends on bmid_pkg, bmid_req_if, bmid_rsp_if and the divider RTL.

module tb;
    import bmid_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [3:0]        offset;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] keep_mask;
    } bus_access_t;

    localparam logic [2:0] RD_UNUSED_A = 3'd3;
    localparam logic [2:0] RD_UNUSED_B = 3'd7;
    localparam int RANDOM_ACCESSES = 950;
    localparam int TAIL_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 40;

    logic clk;
    logic rst_n;

    bmid_req_if req_ch ();
    bmid_rsp_if rsp_ch ();

    bus_mapped_integer_divider uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bus_access_t       access_q[$];
    logic [WORD_W-1:0] read_word_q[$];
    bus_access_t       next_access;
    logic [WORD_W-1:0] expected_word;

    // divider register image
    logic [WORD_W-1:0] m_div_hi;
    logic [WORD_W-1:0] m_div_lo;
    logic [WORD_W-1:0] m_divisor;
    logic [WORD_W-1:0] m_res_hi;
    logic [WORD_W-1:0] m_res_lo;
    logic [FLAG_W-1:0] m_flags;

    int unsigned req_gap;
    int unsigned req_calm;
    int unsigned rsp_stall;
    int unsigned rsp_calm;
    int unsigned idle_cycles;
    int unsigned error_count;
    int unsigned accesses_done;
    int unsigned reads_checked;
    int unsigned signed_divs;
    int unsigned unsigned_divs;
    int unsigned zero_divs;
    int unsigned overflows;
    int unsigned directed_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: MISMATCH %s: got %h expected %h", $time, what, got, want);
    endtask

    function automatic logic [3:0] wr_ofs(input logic start, input logic mode,
                                          input logic [1:0] sel);
        return {start, mode, sel};
    endfunction

    task automatic add_access(input logic kind, input logic [3:0] offset,
                              input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] keep);
        bus_access_t a;
        a.kind       = kind;
        a.offset     = offset;
        a.write_data = data;
        a.keep_mask  = keep;
        access_q.push_back(a);
    endtask

    // mostly short gaps, a few long ones, and stretches with none
    task automatic next_gap(inout int unsigned calm, output int unsigned gap);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm != 0) begin
            calm--;
            gap = 0;
        end
        else begin
            if (roll < 4)
                calm = $urandom_range(20, 80);
            if (roll < 55)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(5, 40);
        end
    endtask

    // updates the register image for one accepted item; reads queue their word
    task automatic track_access(input bus_access_t a);
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  uq;
        logic [WORD_W-1:0] word;
        longint            sn;
        longint            sd;
        longint            sq;
        longint            sr;
        accesses_done++;
        if (a.kind == KIND_WRITE) begin
            case (a.offset[1:0])
                SEL_DIV_HI:  m_div_hi  = (m_div_hi & a.keep_mask) | (a.write_data & ~a.keep_mask);
                SEL_DIV_LO:  m_div_lo  = (m_div_lo & a.keep_mask) | (a.write_data & ~a.keep_mask);
                SEL_DIVISOR: m_divisor = (m_divisor & a.keep_mask)
                                         | (a.write_data & ~a.keep_mask);
                default: ;
            endcase
            if (a.offset[OFS_START_BIT]) begin
                num     = {m_div_hi, m_div_lo};
                m_flags = '0;
                if (m_divisor == '0) begin
                    m_flags[FLAG_ZERO_DIV] = 1'b1;
                    zero_divs++;
                end
                if (a.offset[OFS_MODE_BIT]) begin
                    unsigned_divs++;
                    if (m_divisor == '0)
                        uq = num;
                    else
                        uq = num / {{WORD_W{1'b0}}, m_divisor};
                    m_res_hi = uq[NUM_W-1:WORD_W];
                    m_res_lo = uq[WORD_W-1:0];
                end
                else begin
                    signed_divs++;
                    sn = longint'($signed(num));
                    sd = longint'($signed(m_divisor));
                    if (sd == 0)
                        sq = sn;
                    else
                        sq = sn / sd;
                    sr = sn - sq * sd;
                    if (sq < -32768) begin
                        sq = -32768;
                        m_flags[FLAG_OVERFLOW] = 1'b1;
                    end
                    else if (sq > 32767) begin
                        sq = 32767;
                        m_flags[FLAG_OVERFLOW] = 1'b1;
                    end
                    if (m_flags[FLAG_OVERFLOW])
                        overflows++;
                    m_res_hi = sq[WORD_W-1:0];
                    m_res_lo = sr[WORD_W-1:0];
                end
            end
        end
        else begin
            case (a.offset[2:0])
                RD_DIV_HI:  word = m_div_hi;
                RD_DIV_LO:  word = m_div_lo;
                RD_DIVISOR: word = m_divisor;
                RD_RES_HI:  word = m_res_hi;
                RD_RES_LO:  word = m_res_lo;
                RD_STATUS:  word = {m_flags, {(WORD_W-FLAG_W){1'b0}}};
                default:    word = UNMAPPED_WORD;
            endcase
            read_word_q.push_back(word);
        end
    endtask

    // loads dividend and divisor in random order, starts a division, reads the results
    task automatic add_division_sequence();
        logic [WORD_W-1:0] vals[3];
        logic [1:0]        sels[3];
        logic [WORD_W-1:0] tmp_val;
        logic [1:0]        tmp_sel;
        logic [WORD_W-1:0] keep;
        logic              mode;
        logic              start_apart;
        int unsigned       j;
        vals[0] = 16'($urandom);
        vals[1] = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1: vals[0] = {WORD_W{vals[1][WORD_W-1]}};
            2:    vals[0] = '0;
            3:    vals[0] = 16'hFFFF;
            4:    vals[0] = $urandom_range(0, 1) ? Q_MIN : Q_MAX;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:       vals[2] = '0;
            1:       vals[2] = 16'hFFFF;
            2:       vals[2] = Q_MIN;
            3:       vals[2] = 16'($urandom_range(1, 15));
            4:       vals[2] = Q_MAX;
            default: vals[2] = 16'($urandom);
        endcase
        sels[0] = SEL_DIV_HI;
        sels[1] = SEL_DIV_LO;
        sels[2] = SEL_DIVISOR;
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp_val = vals[i];
            tmp_sel = sels[i];
            vals[i] = vals[j];
            sels[i] = sels[j];
            vals[j] = tmp_val;
            sels[j] = tmp_sel;
        end
        mode        = 1'($urandom_range(0, 1));
        start_apart = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 3; i++) begin
            keep = ($urandom_range(0, 4) == 0) ? 16'($urandom) : '0;
            if (i == 2 || $urandom_range(0, 7) != 0)
                add_access(KIND_WRITE, wr_ofs(i == 2 && !start_apart, mode, sels[i]),
                           vals[i], keep);
        end
        if (start_apart)
            add_access(KIND_WRITE, wr_ofs(1'b1, mode, SEL_NONE), 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 6) != 0)
            add_access(KIND_READ, {1'($urandom), RD_RES_HI}, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 6) != 0)
            add_access(KIND_READ, {1'($urandom), RD_RES_LO}, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) != 0)
            add_access(KIND_READ, {1'($urandom), RD_STATUS}, 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 5) == 0)
            add_access(KIND_READ, {1'($urandom), 3'($urandom)}, 16'($urandom),
                       16'($urandom));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_READ;
            req_ch.offset     <= '0;
            req_ch.write_data <= '0;
            req_ch.keep_mask  <= '0;
            req_gap  = 0;
            req_calm = 0;
        end
        else begin
            if (req_ch.valid && req_ch.ready)
                track_access({req_ch.kind, req_ch.offset, req_ch.write_data, req_ch.keep_mask});
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap != 0) begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (access_q.size() != 0) begin
                    next_access = access_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.kind       <= next_access.kind;
                    req_ch.offset     <= next_access.offset;
                    req_ch.write_data <= next_access.write_data;
                    req_ch.keep_mask  <= next_access.keep_mask;
                    next_gap(req_calm, req_gap);
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and ready driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
            rsp_calm  = 0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (read_word_q.size() == 0) begin
                    report_mismatch("read word with no read pending", rsp_ch.read_data, 'x);
                end
                else begin
                    expected_word = read_word_q.pop_front();
                    reads_checked++;
                    if (rsp_ch.read_data !== expected_word)
                        report_mismatch("read_data", rsp_ch.read_data, expected_word);
                end
            end
            if (rsp_stall != 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
                next_gap(rsp_calm, rsp_stall);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog expired, %0d cycles without an accepted item",
                 $time, idle_cycles);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_READ;
        req_ch.offset     = '0;
        req_ch.write_data = '0;
        req_ch.keep_mask  = '0;
        rsp_ch.ready      = 1'b0;
        m_div_hi  = '0;
        m_div_lo  = '0;
        m_divisor = '0;
        m_res_hi  = '0;
        m_res_lo  = '0;
        m_flags   = '0;
        idle_cycles   = 0;
        error_count   = 0;
        accesses_done = 0;
        reads_checked = 0;
        signed_divs   = 0;
        unsigned_divs = 0;
        zero_divs     = 0;
        overflows     = 0;

        // directed: reset values, unmapped words, min int by -1, zero divisors, masked write
        add_access(KIND_READ, {1'b0, RD_STATUS}, '0, '0);
        add_access(KIND_READ, {1'b1, RD_UNUSED_B}, 16'hFFFF, 16'hFFFF);
        add_access(KIND_WRITE, wr_ofs(1'b0, 1'b0, SEL_DIV_HI), Q_MIN, '0);
        add_access(KIND_WRITE, wr_ofs(1'b0, 1'b0, SEL_DIV_LO), 16'h0000, '0);
        add_access(KIND_WRITE, wr_ofs(1'b1, 1'b0, SEL_DIVISOR), 16'hFFFF, '0);
        add_access(KIND_READ, {1'b0, RD_RES_HI}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_RES_LO}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_STATUS}, '0, '0);
        add_access(KIND_WRITE, wr_ofs(1'b0, 1'b0, SEL_DIVISOR), '0, '0);
        add_access(KIND_WRITE, wr_ofs(1'b1, 1'b0, SEL_NONE), 16'hFFFF, '0);
        add_access(KIND_READ, {1'b1, RD_RES_HI}, '0, '0);
        add_access(KIND_READ, {1'b1, RD_RES_LO}, '0, '0);
        add_access(KIND_READ, {1'b1, RD_STATUS}, '0, '0);
        add_access(KIND_WRITE, wr_ofs(1'b1, 1'b1, SEL_NONE), '0, 16'hFFFF);
        add_access(KIND_READ, {1'b0, RD_RES_HI}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_RES_LO}, '0, '0);
        add_access(KIND_WRITE, wr_ofs(1'b0, 1'b0, SEL_DIV_HI), 16'h007F, 16'hFF00);
        add_access(KIND_WRITE, wr_ofs(1'b1, 1'b0, SEL_DIVISOR), 16'h0002, '0);
        add_access(KIND_READ, {1'b0, RD_DIV_HI}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_RES_HI}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_RES_LO}, '0, '0);
        add_access(KIND_READ, {1'b0, RD_STATUS}, '0, '0);
        add_access(KIND_READ, {1'b1, RD_UNUSED_A}, '0, '0);
        add_access(KIND_WRITE, wr_ofs(1'b1, 1'b1, SEL_DIV_LO), 16'hFFFF, '0);
        add_access(KIND_READ, {1'b0, RD_RES_LO}, '0, '0);
        directed_count = access_q.size();

        while (access_q.size() < directed_count + RANDOM_ACCESSES) begin
            if ($urandom_range(0, 9) < 7) begin
                add_division_sequence();
            end
            else begin
                repeat ($urandom_range(1, 3))
                    add_access(1'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (access_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (read_word_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d bus items, %0d read words checked, %0d errors.",
                 accesses_done, reads_checked, error_count);
        $display("Divisions: %0d signed, %0d unsigned, %0d by zero, %0d saturated.",
                 signed_divs, unsigned_divs, zero_divs, overflows);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
